/* rtl/owm_pkg.sv */
// Shared types, codes and timing defaults for the one-wire bus master.
package owm_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 10;
    localparam int CMD_W               = 3;
    localparam int CFG_COUNT           = 8;
    localparam int CFG_INDEX_W         = $clog2(CFG_COUNT);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MEASURE = 3'd4;

    // Timing register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_RECOVERY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ONE_LOW  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_RELEASE   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LOW       = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_RECOVERY  = 3'd7;

    // Timing defaults, in ticks, wide enough for the largest count width
    localparam logic [15:0] RESET_LOW_DEFAULT      = 16'd480;
    localparam logic [15:0] PRESENCE_WAIT_DEFAULT  = 16'd80;
    localparam logic [15:0] RESET_RECOVERY_DEFAULT = 16'd400;
    localparam logic [15:0] WRITE_ONE_LOW_DEFAULT  = 16'd1;
    localparam logic [15:0] WRITE_ZERO_LOW_DEFAULT = 16'd60;
    localparam logic [15:0] SLOT_RELEASE_DEFAULT   = 16'd60;
    localparam logic [15:0] READ_LOW_DEFAULT       = 16'd2;
    localparam logic [15:0] ZERO_RECOVERY_DEFAULT  = 16'd0;

    localparam logic [CFG_COUNT-1:0][15:0] TIMING_DEFAULTS = {
        ZERO_RECOVERY_DEFAULT, READ_LOW_DEFAULT, SLOT_RELEASE_DEFAULT,
        WRITE_ZERO_LOW_DEFAULT, WRITE_ONE_LOW_DEFAULT, RESET_RECOVERY_DEFAULT,
        PRESENCE_WAIT_DEFAULT, RESET_LOW_DEFAULT
    };

    // Bus command bytes of the measure sequence
    localparam logic [7:0] ROM_SKIP        = 8'hCC;
    localparam logic [7:0] FN_CONVERT      = 8'h44;
    localparam logic [7:0] FN_READ_SCRATCH = 8'hBE;

    // Measure sequence steps
    localparam logic [2:0] SEQ_RESET1    = 3'd0;
    localparam logic [2:0] SEQ_SKIP1     = 3'd1;
    localparam logic [2:0] SEQ_CONVERT   = 3'd2;
    localparam logic [2:0] SEQ_RESET2    = 3'd3;
    localparam logic [2:0] SEQ_SKIP2     = 3'd4;
    localparam logic [2:0] SEQ_SCRATCH   = 3'd5;
    localparam logic [2:0] SEQ_READ_LOW  = 3'd6;
    localparam logic [2:0] SEQ_READ_HIGH = 3'd7;

    typedef enum logic [7:0] {
        PH_IDLE     = 8'b0000_0001,
        PH_RST_LOW  = 8'b0000_0010,
        PH_RST_WAIT = 8'b0000_0100,
        PH_RST_REC  = 8'b0000_1000,
        PH_W_LOW    = 8'b0001_0000,
        PH_W_REL    = 8'b0010_0000,
        PH_R_LOW    = 8'b0100_0000,
        PH_R_REL    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic [2:0]       bitpos;
        logic [7:0]       shift;
        logic [2:0]       step;
        logic [7:0]       low_temp;
        logic             presence;
        logic [CMD_W-1:0] cmd;
    } owm_state_t;

    typedef struct packed {
        logic        done;
        logic [7:0]  rd_byte;
        logic [15:0] temp;
    } owm_fin_t;

endpackage

/* rtl/owm_step.sv */
// Command start and one phase transition of the one-wire sequencer.
module owm_step #(
    parameter int COUNT_WIDTH = owm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  owm_pkg::owm_state_t                                st_in,
    input  logic [COUNT_WIDTH-1:0]                             cnt_in,
    input  owm_pkg::owm_fin_t                                  fin_in,
    input  logic [owm_pkg::CMD_W-1:0]                          cmd,
    input  logic [7:0]                                         data,
    input  logic                                               line_lvl,
    input  logic [owm_pkg::CFG_COUNT-1:0][COUNT_WIDTH-1:0]     tim,
    output owm_pkg::owm_state_t                                st_out,
    output logic [COUNT_WIDTH-1:0]                             cnt_out,
    output owm_pkg::owm_fin_t                                  fin_out
);
    import owm_pkg::*;

    owm_state_t             s;
    logic [COUNT_WIDTH-1:0] c;
    owm_fin_t               f;
    logic                   start;
    logic                   end_now;
    logic                   do_write;
    logic [7:0]             wr_val;

    assign start = (st_in.phase == PH_IDLE) &&
                   (cmd == CMD_RESET || cmd == CMD_WRITE ||
                    cmd == CMD_READ || cmd == CMD_MEASURE);

    always_comb
    begin
        s        = st_in;
        c        = cnt_in;
        f        = fin_in;
        end_now  = 1'b0;
        do_write = 1'b0;
        wr_val   = '0;

        // new command, only from idle
        if (start)
        begin
            s.cmd  = cmd;
            s.step = SEQ_RESET1;
            if (cmd == CMD_WRITE)
            begin
                s.shift  = data;
                s.bitpos = '0;
                s.phase  = PH_W_LOW;
                c        = data[0] ? tim[CFG_WRITE_ONE_LOW] : tim[CFG_WRITE_ZERO_LOW];
            end
            else if (cmd == CMD_READ)
            begin
                s.shift  = '0;
                s.bitpos = '0;
                s.phase  = PH_R_LOW;
                c        = tim[CFG_READ_LOW];
            end
            else
            begin
                s.phase = PH_RST_LOW;
                c       = tim[CFG_RESET_LOW];
            end
        end

        // phase whose time is used up moves on
        if (s.phase != PH_IDLE && c == '0)
        begin
            unique case (s.phase)
                PH_RST_LOW:
                begin
                    s.phase = PH_RST_WAIT;
                    c       = tim[CFG_PRESENCE_WAIT];
                end
                PH_RST_WAIT:
                begin
                    s.presence = ~line_lvl;
                    s.phase    = PH_RST_REC;
                    c          = tim[CFG_RESET_RECOVERY];
                end
                PH_RST_REC:
                begin
                    end_now = 1'b1;
                end
                PH_W_LOW:
                begin
                    s.phase = PH_W_REL;
                    c = s.shift[0] ? tim[CFG_SLOT_RELEASE] : tim[CFG_ZERO_RECOVERY];
                end
                PH_W_REL:
                begin
                    s.shift = {1'b0, s.shift[7:1]};
                    if (s.bitpos == 3'd7)
                    begin
                        end_now = 1'b1;
                    end
                    else
                    begin
                        s.bitpos = s.bitpos + 3'd1;
                        s.phase  = PH_W_LOW;
                        c = s.shift[0] ? tim[CFG_WRITE_ONE_LOW] : tim[CFG_WRITE_ZERO_LOW];
                    end
                end
                PH_R_LOW:
                begin
                    s.shift = {line_lvl, s.shift[7:1]};
                    s.phase = PH_R_REL;
                    c       = tim[CFG_SLOT_RELEASE];
                end
                PH_R_REL:
                begin
                    if (s.bitpos == 3'd7)
                    begin
                        end_now = 1'b1;
                    end
                    else
                    begin
                        s.bitpos = s.bitpos + 3'd1;
                        s.phase  = PH_R_LOW;
                        c        = tim[CFG_READ_LOW];
                    end
                end
                default:
                begin
                    s.phase = PH_IDLE;
                    c       = '0;
                end
            endcase
        end

        // end of a command step: finish or start the next measure step
        if (end_now)
        begin
            if (s.cmd != CMD_MEASURE)
            begin
                s.phase   = PH_IDLE;
                c         = '0;
                f.done    = 1'b1;
                f.rd_byte = (s.cmd == CMD_READ) ? s.shift : 8'd0;
                f.temp    = '0;
            end
            else if ((s.step == SEQ_RESET1 || s.step == SEQ_RESET2) && !s.presence)
            begin
                s.phase   = PH_IDLE;
                c         = '0;
                f.done    = 1'b1;
                f.rd_byte = '0;
                f.temp    = '0;
            end
            else if (s.step == SEQ_READ_HIGH)
            begin
                s.phase   = PH_IDLE;
                c         = '0;
                f.done    = 1'b1;
                f.rd_byte = '0;
                f.temp    = {s.shift, s.low_temp};
            end
            else
            begin
                if (s.step == SEQ_READ_LOW)
                begin
                    s.low_temp = s.shift;
                end
                s.step = s.step + 3'd1;
                unique case (s.step)
                    SEQ_RESET1, SEQ_RESET2:
                    begin
                        s.phase = PH_RST_LOW;
                        c       = tim[CFG_RESET_LOW];
                    end
                    SEQ_SKIP1, SEQ_SKIP2:
                    begin
                        do_write = 1'b1;
                        wr_val   = ROM_SKIP;
                    end
                    SEQ_CONVERT:
                    begin
                        do_write = 1'b1;
                        wr_val   = FN_CONVERT;
                    end
                    SEQ_SCRATCH:
                    begin
                        do_write = 1'b1;
                        wr_val   = FN_READ_SCRATCH;
                    end
                    SEQ_READ_LOW, SEQ_READ_HIGH:
                    begin
                        s.shift  = '0;
                        s.bitpos = '0;
                        s.phase  = PH_R_LOW;
                        c        = tim[CFG_READ_LOW];
                    end
                endcase
                if (do_write)
                begin
                    s.shift  = wr_val;
                    s.bitpos = '0;
                    s.phase  = PH_W_LOW;
                    c = wr_val[0] ? tim[CFG_WRITE_ONE_LOW] : tim[CFG_WRITE_ZERO_LOW];
                end
            end
        end
    end

    assign st_out  = s;
    assign cnt_out = c;
    assign fin_out = f;

endmodule

/* rtl/one_wire_master_temperature_reader.sv */
// A tick transfer lands in the input register; its result is then registered in the result register.
// Throughput: one tick per cycle while a tick makes at most two phase transitions and the
// result channel does not stall; a tick with more holds the input until all of them are done.
// The two chained sequencer steps per cycle set that figure.
// Reset (rst_n low, asynchronous): timing registers take their defaults, the sequencer
// goes idle with all state cleared, and both channels are empty.
module one_wire_master_temperature_reader #(
    parameter int COUNT_WIDTH = owm_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // timing register writes
    input  logic                                cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [COUNT_WIDTH-1:0]              cfg_data,
    // tick channel
    input  logic                                item_valid,
    output logic                                item_ready,
    input  logic [owm_pkg::CMD_W-1:0]           command,
    input  logic [7:0]                          data_byte,
    input  logic                                line_level,
    // result channel
    output logic                                result_valid,
    input  logic                                result_ready,
    output logic                                drive_low,
    output logic                                busy_res,
    output logic                                done_res,
    output logic                                presence_ok,
    output logic [7:0]                          read_byte,
    output logic signed [15:0]                  temperature
);
    import owm_pkg::*;

    // Timing registers
    logic [CFG_COUNT-1:0][COUNT_WIDTH-1:0] tim_reg;

    // Sequencer state
    owm_state_t             st_reg;
    logic [COUNT_WIDTH-1:0] cnt_reg;

    // Input register: the tick being worked on. started_reg marks that its
    // command has already been applied; fin_reg keeps a completion seen in
    // an earlier cycle of the same tick.
    logic               itm_valid_reg;
    logic [CMD_W-1:0]   itm_cmd_reg;
    logic [7:0]         itm_data_reg;
    logic               itm_line_reg;
    logic               started_reg;
    owm_fin_t           fin_reg;

    // Result register
    logic               result_valid_reg;
    logic               drive_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               presence_reg;
    logic [7:0]         byte_reg;
    logic [15:0]        temp_reg;

    // Two chained sequencer steps
    owm_state_t             st_a;
    owm_state_t             st_b;
    logic [COUNT_WIDTH-1:0] cnt_a;
    logic [COUNT_WIDTH-1:0] cnt_b;
    owm_fin_t               fin_a;
    owm_fin_t               fin_b;
    owm_fin_t               fin_start;
    logic [CMD_W-1:0]       cmd_a;

    logic out_free;
    logic run;
    logic settled;
    logic take;

    // command only applied on the first cycle of a tick
    assign cmd_a     = started_reg ? CMD_NONE : itm_cmd_reg;
    assign fin_start = started_reg ? fin_reg : owm_fin_t'('0);

    owm_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step_a (
        .st_in    (st_reg),
        .cnt_in   (cnt_reg),
        .fin_in   (fin_start),
        .cmd      (cmd_a),
        .data     (itm_data_reg),
        .line_lvl (itm_line_reg),
        .tim      (tim_reg),
        .st_out   (st_a),
        .cnt_out  (cnt_a),
        .fin_out  (fin_a)
    );

    owm_step #(.COUNT_WIDTH(COUNT_WIDTH)) u_step_b (
        .st_in    (st_a),
        .cnt_in   (cnt_a),
        .fin_in   (fin_a),
        .cmd      (CMD_NONE),
        .data     (itm_data_reg),
        .line_lvl (itm_line_reg),
        .tim      (tim_reg),
        .st_out   (st_b),
        .cnt_out  (cnt_b),
        .fin_out  (fin_b)
    );

    // Work only when the result register can take the outcome; a stall
    // freezes the sequencer so nothing is committed twice.
    assign out_free   = !result_valid_reg || result_ready;
    assign run        = itm_valid_reg && out_free;
    // tick is settled when the sequencer is idle or has time left to count
    assign settled    = (st_b.phase == PH_IDLE) || (cnt_b != '0);
    assign item_ready = !itm_valid_reg || (run && settled);
    assign take       = item_valid && item_ready;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_COUNT; i++)
            begin
                tim_reg[i] <= TIMING_DEFAULTS[i][COUNT_WIDTH-1:0];
            end
        end
        else if (cfg_we)
        begin
            tim_reg[cfg_index] <= cfg_data;
        end
    end

    // Sequencer and channel control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase     <= PH_IDLE;
            st_reg.bitpos    <= '0;
            st_reg.shift     <= '0;
            st_reg.step      <= '0;
            st_reg.low_temp  <= '0;
            st_reg.presence  <= 1'b0;
            st_reg.cmd       <= CMD_NONE;
            cnt_reg          <= '0;
            itm_valid_reg    <= 1'b0;
            started_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (run)
            begin
                st_reg <= st_b;
                // the tick spends one count of the phase it ends in
                if (settled && st_b.phase != PH_IDLE)
                begin
                    cnt_reg <= cnt_b - {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                end
                else
                begin
                    cnt_reg <= cnt_b;
                end
                // a new tick only enters after a settled one, so this clears it too
                started_reg <= !settled;
            end

            if (take)
            begin
                itm_valid_reg <= 1'b1;
            end
            else if (run && settled)
            begin
                itm_valid_reg <= 1'b0;
            end

            if (run && settled)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            itm_cmd_reg  <= command;
            itm_data_reg <= data_byte;
            itm_line_reg <= line_level;
        end
        if (run && !settled)
        begin
            fin_reg <= fin_b;
        end
        if (run && settled)
        begin
            drive_reg    <= (st_b.phase == PH_RST_LOW) || (st_b.phase == PH_W_LOW) ||
                            (st_b.phase == PH_R_LOW);
            busy_reg     <= (st_b.phase != PH_IDLE);
            done_reg     <= fin_b.done;
            presence_reg <= fin_b.done & st_b.presence;
            byte_reg     <= fin_b.done ? fin_b.rd_byte : 8'd0;
            temp_reg     <= fin_b.done ? fin_b.temp : 16'd0;
        end
    end

    assign result_valid = result_valid_reg;
    assign drive_low    = drive_reg;
    assign busy_res     = busy_reg;
    assign done_res     = done_reg;
    assign presence_ok  = presence_reg;
    assign read_byte    = byte_reg;
    assign temperature  = signed'(temp_reg);

`ifndef NO_ASSERTIONS
    // a completion tick never drives the bus or reports busy
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && done_res) |-> (!busy_res && !drive_low))
        else $error("done result with bus drive or busy");

    // status fields stay zero off a completion tick
    a_status_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !done_res) |->
            (!presence_ok && read_byte == 8'd0 && temperature == 16'sd0))
        else $error("status fields set without done");

    // a partly processed tick still holds its input
    a_started_held: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> itm_valid_reg)
        else $error("started flag without a tick in the input register");

    // idle sequencer keeps no pending time
    a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg.phase == PH_IDLE) |-> (cnt_reg == '0))
        else $error("idle sequencer with nonzero count");
`endif

endmodule

/* verif/one_wire_master_temperature_reader_checker.sv */
`timescale 1ns / 1ps
// Checker for the one-wire master: predicts each tick result and compares it.
module one_wire_master_temperature_reader_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [owm_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [owm_pkg::COUNT_WIDTH_DEFAULT-1:0] cfg_data,
    input  logic                                    item_valid,
    input  logic                                    item_ready,
    input  logic [owm_pkg::CMD_W-1:0]               command,
    input  logic [7:0]                              data_byte,
    input  logic                                    line_level,
    input  logic                                    result_valid,
    input  logic                                    result_ready,
    input  logic                                    drive_low,
    input  logic                                    busy_res,
    input  logic                                    done_res,
    input  logic                                    presence_ok,
    input  logic [7:0]                              read_byte,
    input  logic signed [15:0]                      temperature,
    output int unsigned                             mismatches,
    output int unsigned                             outstanding,
    output logic                                    model_busy,
    output owm_pkg::phase_t                         model_phase
);
    import owm_pkg::*;

    localparam int CW           = COUNT_WIDTH_DEFAULT;
    localparam int CHAIN_LIMIT  = 512;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic               drive;
        logic               busy;
        logic               done;
        logic               presence;
        logic [7:0]         rd_byte;
        logic signed [15:0] temp;
    } tick_result_t;

    // predictor state
    logic [CW-1:0]    timing [CFG_COUNT];
    phase_t           bus_phase;
    logic [CW-1:0]    slot_count;
    logic [2:0]       bit_pos;
    logic [7:0]       shift_reg;
    logic [3:0]       seq_step;
    logic [7:0]       low_temp;
    logic             presence_seen;
    logic [CMD_W-1:0] active_cmd;
    logic             fin_done;
    logic [7:0]       fin_byte;
    logic [15:0]      fin_temp;

    tick_result_t bus_result_q [$];
    tick_result_t want;
    tick_result_t got;

    function automatic void clear_model();
        for (int i = 0; i < CFG_COUNT; i++)
            timing[i] = TIMING_DEFAULTS[i][CW-1:0];
        bus_phase     = PH_IDLE;
        slot_count    = '0;
        bit_pos       = '0;
        shift_reg     = '0;
        seq_step      = '0;
        low_temp      = '0;
        presence_seen = 1'b0;
        active_cmd    = CMD_NONE;
        fin_done      = 1'b0;
        fin_byte      = '0;
        fin_temp      = '0;
    endfunction

    function automatic void enter_phase(phase_t p, logic [CW-1:0] ticks);
        bus_phase  = p;
        slot_count = ticks;
    endfunction

    function automatic void finish_cmd(logic [7:0] rd, logic [15:0] temp);
        bus_phase  = PH_IDLE;
        slot_count = '0;
        fin_done   = 1'b1;
        fin_byte   = rd;
        fin_temp   = temp;
    endfunction

    function automatic void start_write(logic [7:0] v);
        shift_reg = v;
        bit_pos   = '0;
        enter_phase(PH_W_LOW, v[0] ? timing[CFG_WRITE_ONE_LOW] : timing[CFG_WRITE_ZERO_LOW]);
    endfunction

    function automatic void start_read();
        shift_reg = '0;
        bit_pos   = '0;
        enter_phase(PH_R_LOW, timing[CFG_READ_LOW]);
    endfunction

    function automatic void begin_measure_step();
        case (seq_step)
            SEQ_RESET1, SEQ_RESET2: enter_phase(PH_RST_LOW, timing[CFG_RESET_LOW]);
            SEQ_SKIP1, SEQ_SKIP2:   start_write(ROM_SKIP);
            SEQ_CONVERT:            start_write(FN_CONVERT);
            SEQ_SCRATCH:            start_write(FN_READ_SCRATCH);
            default:                start_read();
        endcase
    endfunction

    function automatic void end_step();
        if (active_cmd != CMD_MEASURE) begin
            finish_cmd(active_cmd == CMD_READ ? shift_reg : 8'h00, 16'h0000);
        end else if ((seq_step == SEQ_RESET1 || seq_step == SEQ_RESET2) && !presence_seen) begin
            // a reset of the sequence saw no device: abort
            finish_cmd(8'h00, 16'h0000);
        end else begin
            if (seq_step == SEQ_READ_LOW)
                low_temp = shift_reg;
            if (seq_step >= SEQ_READ_HIGH) begin
                finish_cmd(8'h00, {shift_reg, low_temp});
            end else begin
                seq_step = seq_step + 4'd1;
                begin_measure_step();
            end
        end
    endfunction

    function automatic void advance_phase(logic level);
        case (bus_phase)
            PH_RST_LOW: enter_phase(PH_RST_WAIT, timing[CFG_PRESENCE_WAIT]);
            PH_RST_WAIT: begin
                presence_seen = ~level;
                enter_phase(PH_RST_REC, timing[CFG_RESET_RECOVERY]);
            end
            PH_RST_REC: end_step();
            PH_W_LOW: enter_phase(PH_W_REL, shift_reg[0] ? timing[CFG_SLOT_RELEASE]
                                                         : timing[CFG_ZERO_RECOVERY]);
            PH_W_REL: begin
                shift_reg = shift_reg >> 1;
                if (bit_pos == 3'd7) begin
                    end_step();
                end else begin
                    bit_pos = bit_pos + 3'd1;
                    enter_phase(PH_W_LOW, shift_reg[0] ? timing[CFG_WRITE_ONE_LOW]
                                                       : timing[CFG_WRITE_ZERO_LOW]);
                end
            end
            PH_R_LOW: begin
                shift_reg = {level, shift_reg[7:1]};
                enter_phase(PH_R_REL, timing[CFG_SLOT_RELEASE]);
            end
            PH_R_REL: begin
                if (bit_pos == 3'd7) begin
                    end_step();
                end else begin
                    bit_pos = bit_pos + 3'd1;
                    enter_phase(PH_R_LOW, timing[CFG_READ_LOW]);
                end
            end
            default: begin
                bus_phase  = PH_IDLE;
                slot_count = '0;
            end
        endcase
    endfunction

    // One bus tick: optional command start, zero-length phases chained, then count down.
    function automatic tick_result_t run_bus_tick(logic [CMD_W-1:0] cmd, logic [7:0] data,
                                                  logic level);
        tick_result_t r;
        int           guard;
        r        = '0;
        guard    = 0;
        fin_done = 1'b0;
        fin_byte = '0;
        fin_temp = '0;
        if (bus_phase == PH_IDLE && cmd >= CMD_RESET && cmd <= CMD_MEASURE) begin
            active_cmd = cmd;
            seq_step   = '0;
            if (cmd == CMD_RESET || cmd == CMD_MEASURE)
                enter_phase(PH_RST_LOW, timing[CFG_RESET_LOW]);
            else if (cmd == CMD_WRITE)
                start_write(data);
            else
                start_read();
        end
        while (bus_phase != PH_IDLE && slot_count == '0 && guard < CHAIN_LIMIT) begin
            advance_phase(level);
            guard++;
        end
        if (bus_phase != PH_IDLE) begin
            r.drive = (bus_phase == PH_RST_LOW || bus_phase == PH_W_LOW || bus_phase == PH_R_LOW);
            if (slot_count != '0)
                slot_count = slot_count - 1'b1;
            r.busy = 1'b1;
        end
        r.done = fin_done;
        if (fin_done) begin
            r.presence = presence_seen;
            r.rd_byte  = fin_byte;
            r.temp     = fin_temp;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            bus_result_q.delete();
            mismatches = 0;
        end
        else
        begin
            // results first: a result never matches a tick taken at the same edge
            if (result_valid && result_ready)
            begin
                got.drive    = drive_low;
                got.busy     = busy_res;
                got.done     = done_res;
                got.presence = presence_ok;
                got.rd_byte  = read_byte;
                got.temp     = temperature;
                if (bus_result_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no tick pending: %p", $realtime, got);
                end
                else
                begin
                    want = bus_result_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: mismatch drive %b/%b busy %b/%b done %b/%b ",
                                      "presence %b/%b byte %h/%h temp %0d/%0d (exp/act)"},
                                     $realtime, want.drive, got.drive, want.busy, got.busy,
                                     want.done, got.done, want.presence, got.presence,
                                     want.rd_byte, got.rd_byte, want.temp, got.temp);
                    end
                end
            end
            if (cfg_we)
                timing[cfg_index] = cfg_data;
            if (item_valid && item_ready)
                bus_result_q.push_back(run_bus_tick(command, data_byte, line_level));
        end
        outstanding = bus_result_q.size();
        model_busy  = (bus_phase != PH_IDLE);
        model_phase = bus_phase;
    end

endmodule

/* verif/one_wire_master_temperature_reader_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the one-wire master: stimulus, idling, timing setup and verdict.
module one_wire_master_temperature_reader_tb;
    import owm_pkg::*;

    localparam int            CW               = COUNT_WIDTH_DEFAULT;
    localparam int            RANDOM_TICKS     = 900;
    localparam int            ROUNDS           = 6;
    localparam int            HOLD_AT_TICK     = 100;   // where the long sink hold starts
    localparam int            SINK_HOLD_CYCLES = 300;
    localparam int            TAIL_CYCLES      = 20;
    localparam int            CYCLE_LIMIT      = 400000;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index   = '0;
    logic [CW-1:0]          cfg_data    = '0;
    logic                   item_valid  = 1'b0;
    logic                   item_ready;
    logic [CMD_W-1:0]       command     = CMD_NONE;
    logic [7:0]             data_byte   = 8'h00;
    logic                   line_level  = 1'b1;
    logic                   result_valid;
    logic                   result_ready = 1'b0;
    logic                   drive_low;
    logic                   busy_res;
    logic                   done_res;
    logic                   presence_ok;
    logic [7:0]             read_byte;
    logic signed [15:0]     temperature;

    // checker view
    int unsigned            mismatches;
    int unsigned            outstanding;
    logic                   model_busy;
    phase_t                 model_phase;

    // idling control; the sink hold is requested here and timed in the sink process
    logic                   src_gaps_on        = 1'b1;
    logic                   sink_gaps_on       = 1'b1;
    int                     sink_hold_requests = 0;
    int                     sink_holds_seen    = 0;
    int                     sink_hold_left     = 0;
    int                     cycle_count        = 0;

    logic [CW-1:0]          timing_plan [CFG_COUNT];

    always #1 clk = ~clk;

    one_wire_master_temperature_reader #(
        .COUNT_WIDTH (CW)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .data_byte    (data_byte),
        .line_level   (line_level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive_low    (drive_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .presence_ok  (presence_ok),
        .read_byte    (read_byte),
        .temperature  (temperature)
    );

    one_wire_master_temperature_reader_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .command      (command),
        .data_byte    (data_byte),
        .line_level   (line_level),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .drive_low    (drive_low),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .presence_ok  (presence_ok),
        .read_byte    (read_byte),
        .temperature  (temperature),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .model_busy   (model_busy),
        .model_phase  (model_phase)
    );

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result sink: random back-pressure, plus one long hold counted here when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (sink_holds_seen != sink_hold_requests)
            begin
                sink_holds_seen = sink_hold_requests;
                sink_hold_left  = SINK_HOLD_CYCLES;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                result_ready <= 1'b0;
            end
            else if (sink_gaps_on)
            begin
                result_ready <= ($urandom_range(99) >= 32);
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // The model is in a reset pulse or waiting for presence: the device answers low.
    function automatic logic bus_in_reset();
        return model_phase == PH_RST_LOW || model_phase == PH_RST_WAIT;
    endfunction

    // Bus level for a random tick: mostly a presence answer during resets, else random bits.
    function automatic logic pick_line();
        if (bus_in_reset())
            return ($urandom_range(99) < 15);
        return 1'($urandom_range(1));
    endfunction

    // One tick transfer. Called at a falling edge, returns at the falling edge after the
    // transfer. Valid is left high so back-to-back ticks never toggle it within a step.
    task automatic send_tick(input logic [CMD_W-1:0] c, input logic [7:0] d, input logic level);
        if (src_gaps_on)
        begin
            while ($urandom_range(99) < 32)
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
        end
        item_valid <= 1'b1;
        command    <= c;
        data_byte  <= d;
        line_level <= level;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Run the bus until the block is idle and every result has been taken.
    task automatic settle();
        while (model_busy || outstanding != 0)
        begin
            if (model_busy)
            begin
                send_tick(CMD_NONE, 8'($urandom), pick_line());
            end
            else
            begin
                item_valid <= 1'b0;
                @(negedge clk);
            end
        end
        item_valid <= 1'b0;
        repeat (4) @(negedge clk);
    endtask

    // Write every timing register from the plan, only with the block idle.
    task automatic apply_timing();
        settle();
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= timing_plan[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic plan_all(input logic [CW-1:0] v);
        for (int i = 0; i < CFG_COUNT; i++)
            timing_plan[i] = v;
    endtask

    // Issue a command and keep ticking until done: device answers presence,
    // read slots return read_level.
    task automatic follow_bus(input logic [CMD_W-1:0] c, input logic [7:0] d,
                              input logic read_level);
        send_tick(c, d, read_level);
        while (model_busy)
            send_tick(CMD_NONE, 8'($urandom), bus_in_reset() ? 1'b0 : read_level);
    endtask

    initial
    begin
        int               r;
        int               span;
        logic [CMD_W-1:0] c;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed ----
        // Byte write with the timing defaults left by reset: ones and zeros in the slots.
        follow_bus(CMD_WRITE, 8'h0F, 1'b1);

        // All times zero: every command completes on the tick that issues it.
        plan_all('0);
        apply_timing();
        send_tick(CMD_RESET,   8'h00, 1'b0);    // presence seen
        send_tick(CMD_RESET,   8'h00, 1'b1);    // no presence
        send_tick(CMD_WRITE,   8'h00, 1'b1);
        send_tick(CMD_WRITE,   8'hFF, 1'b0);
        send_tick(CMD_READ,    8'h00, 1'b1);    // reads all ones
        send_tick(CMD_READ,    8'hFF, 1'b0);    // reads all zeros
        send_tick(CMD_MEASURE, 8'h00, 1'b0);    // full sequence, temperature zero
        send_tick(CMD_MEASURE, 8'hFF, 1'b1);    // no presence, aborts after first reset
        send_tick(CMD_NONE,    8'h5A, 1'b1);
        // codes above measure act as plain ticks
        for (int u = 1; u <= 3; u++)
            send_tick(CMD_MEASURE + CMD_W'(u), 8'hFF, 1'b0);

        // One-tick phases: a full measure with both bytes all ones (temperature -1), then a
        // write, with further commands offered while it is busy, which must be ignored.
        plan_all(CW'(1));
        apply_timing();
        follow_bus(CMD_MEASURE, 8'h00, 1'b1);
        send_tick(CMD_WRITE,   8'hA5, 1'b1);
        send_tick(CMD_READ,    8'h00, 1'b1);
        send_tick(CMD_MEASURE, 8'h3C, 1'b0);
        send_tick(CMD_RESET,   8'hC3, 1'b1);
        settle();

        // ---- random ----
        // Each round draws short phase times.
        // Round 1 runs without any idling; round 2 carries the long sink hold.
        for (int k = 0; k < ROUNDS; k++)
        begin
            span = 1 + (k % 3) + (k / 4);
            for (int i = 0; i < CFG_COUNT; i++)
                timing_plan[i] = CW'($urandom_range(span));
            src_gaps_on  = (k != 1);
            sink_gaps_on = (k != 1);
            apply_timing();
            for (int n = 0; n < RANDOM_TICKS / ROUNDS; n++)
            begin
                if (k == 2 && n == HOLD_AT_TICK)
                    sink_hold_requests++;
                if (!model_busy)
                begin
                    // mostly real commands, weighted toward the measure sequence
                    r = $urandom_range(99);
                    if (r < 75)
                    begin
                        case ($urandom_range(9))
                            0, 1, 2, 3: c = CMD_MEASURE;
                            4, 5:       c = CMD_READ;
                            6, 7:       c = CMD_WRITE;
                            default:    c = CMD_RESET;
                        endcase
                    end
                    else if (r < 90)
                    begin
                        c = CMD_NONE;
                    end
                    else
                    begin
                        c = CMD_MEASURE + CMD_W'($urandom_range(1, 3));
                    end
                end
                else
                begin
                    // noise while busy: stray commands that must not take effect
                    c = ($urandom_range(99) < 15) ? CMD_W'($urandom_range(7)) : CMD_NONE;
                end
                send_tick(c, 8'($urandom), pick_line());
            end
        end

        settle();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/owm_pkg.sv
rtl/owm_step.sv
rtl/one_wire_master_temperature_reader.sv
verif/one_wire_master_temperature_reader_checker.sv
verif/one_wire_master_temperature_reader_tb.sv
